// ===== src/ilb_pkg.sv =====
// shared types and constants for the indexed list buffer
`timescale 1ns / 1ps

package ilb_pkg;

    // default sizing of the element store
    localparam int DEF_CAPACITY      = 256;
    localparam int DEF_ELEMENT_WIDTH = 32;

    // fixed field widths of the request and result words
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 9;
    localparam int STATUS_W = 2;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SET    = 2'd1,
        OP_GET    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic do_append;
        logic do_set;
        logic do_get;
        logic shift_start;
        logic shift_step;
        logic remove_commit;
        logic load_out;
    } ilb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  req_op;
        logic full;
        logic range_err;
        logic shift_done;
        logic out_free;
    } ilb_stat_t;

endpackage

// ===== src/ilb_datapath.sv =====
// datapath: request register, element memory, count and size registers, result register
`timescale 1ns / 1ps

module ilb_datapath #(
    parameter int CAPACITY      = ilb_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = ilb_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ilb_pkg::ilb_cmd_t              cmd,
    output ilb_pkg::ilb_stat_t             stat,
    input  logic [ilb_pkg::OP_W-1:0]       op,
    input  logic [ilb_pkg::INDEX_W-1:0]    index,
    input  logic [ilb_pkg::VALUE_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ilb_pkg::VALUE_W-1:0]    read_value,
    output logic [ilb_pkg::LENGTH_W-1:0]   length,
    output logic [ilb_pkg::LENGTH_W-1:0]   alloc_size,
    output logic [ilb_pkg::STATUS_W-1:0]   status
);
    import ilb_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_X = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // request register
    op_t                      req_op_reg;
    logic [INDEX_W-1:0]       req_index_reg;
    logic [ELEMENT_WIDTH-1:0] req_value_reg;

    // list bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] size_reg, size_next;

    // shift walker
    logic [CW-1:0] ptr_reg;
    logic          pend_reg;
    logic [AW-1:0] wr_addr_reg;

    // latched outcome of the request
    status_t st_reg;
    logic    get_reg;

    // element memory
    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic                     we;
    logic [AW-1:0]            wa;
    logic [ELEMENT_WIDTH-1:0] wd;
    logic                     re;
    logic [AW-1:0]            ra;

    // result register
    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic [LENGTH_W-1:0]   alloc_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic          full;
    logic          range_err;
    logic          ptr_lt;
    logic [CW:0]   size_x2;
    logic [CW-1:0] size_grown;
    logic [CW-1:0] count_dec;
    logic          shrink_hit;
    status_t       st_now;

    // capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg    <= op_t'(op);
            req_index_reg <= index;
            req_value_reg <= ELEMENT_WIDTH'(value);
        end
    end

    // request checks
    assign full      = (count_reg == CAP_C);
    assign range_err = (CMPW'(req_index_reg) >= CMPW'(count_reg));
    assign ptr_lt    = (ptr_reg < count_reg);

    always_comb
    begin
        case (req_op_reg)
            OP_APPEND: st_now = full ? ST_FULL : ST_OK;
            default:   st_now = range_err ? ST_RANGE : ST_OK;
        endcase
    end

    // growth and shrink of the nominal size
    assign size_x2    = {size_reg, 1'b0};
    assign size_grown = (size_x2 > CAP_X) ? CAP_C : size_x2[CW-1:0];
    assign count_dec  = count_reg - ONE_C;
    assign shrink_hit = (count_dec <= (size_reg >> 2)) && (size_reg != ONE_C);

    always_comb
    begin
        count_next = count_reg;
        size_next  = size_reg;
        if (cmd.do_append)
        begin
            count_next = count_reg + ONE_C;
            if (count_reg == size_reg)
                size_next = size_grown;
        end
        else if (cmd.remove_commit)
        begin
            count_next = count_dec;
            if (shrink_hit)
                size_next = size_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            size_reg  <= ONE_C;
        end
        else
        begin
            count_reg <= count_next;
            size_reg  <= size_next;
        end
    end

    // memory port selection
    always_comb
    begin
        we = 1'b0;
        wa = AW'(count_reg);
        wd = req_value_reg;
        if (cmd.do_append)
        begin
            we = 1'b1;
        end
        else if (cmd.do_set)
        begin
            we = 1'b1;
            wa = AW'(req_index_reg);
        end
        else if (pend_reg)
        begin
            we = 1'b1;
            wa = wr_addr_reg;
            wd = rd_data_reg;
        end

        re = 1'b0;
        ra = AW'(req_index_reg);
        if (cmd.do_get)
        begin
            re = 1'b1;
        end
        else if (cmd.shift_step && ptr_lt)
        begin
            re = 1'b1;
            ra = AW'(ptr_reg);
        end
    end

    // element store, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_data_reg <= mem[ra];
    end

    // shift walker: read one place up, write it back one place down in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            wr_addr_reg <= '0;
        end
        else if (cmd.shift_start)
        begin
            ptr_reg  <= CW'(req_index_reg) + ONE_C;
            pend_reg <= 1'b0;
        end
        else if (cmd.shift_step)
        begin
            if (ptr_lt)
                ptr_reg <= ptr_reg + ONE_C;
            pend_reg    <= ptr_lt;
            wr_addr_reg <= AW'(ptr_reg - ONE_C);
        end
        else
        begin
            pend_reg <= 1'b0;
        end
    end

    // outcome of the request
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_reg  <= st_now;
            get_reg <= cmd.do_get;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_value_reg <= get_reg ? VALUE_W'(rd_data_reg) : '0;
            length_reg     <= LENGTH_W'(count_reg);
            alloc_reg      <= LENGTH_W'(size_reg);
            status_reg     <= STATUS_W'(st_reg);
        end
    end

    // status to the controller
    assign stat.req_op     = req_op_reg;
    assign stat.full       = full;
    assign stat.range_err  = range_err;
    assign stat.shift_done = !ptr_lt && !pend_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;
    assign alloc_size = alloc_reg;
    assign status     = status_reg;

endmodule

// ===== src/ilb_ctrl.sv =====
// controller state machine sequencing each request through the datapath
`timescale 1ns / 1ps

module ilb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output ilb_pkg::ilb_cmd_t  cmd,
    input  ilb_pkg::ilb_stat_t stat
);
    import ilb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FINISH;
                case (stat.req_op)
                    OP_APPEND: cmd.do_append = !stat.full;
                    OP_SET:    cmd.do_set    = !stat.range_err;
                    OP_GET:    cmd.do_get    = !stat.range_err;
                    OP_REMOVE:
                    begin
                        if (!stat.range_err)
                        begin
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    cmd.remove_commit = 1'b1;
                    state_next        = S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== src/indexed_list_buffer_core.sv =====
// indexed list buffer: ordered element store with append, set, get and remove
//
// Request channel (in_valid/in_ready) carries one word: op, index, value.
// Result channel (out_valid/out_ready) returns one word per request:
// read_value (element for a good get, else zero), length, alloc_size, status.
// Requests are handled one at a time. A request is taken only in the idle
// state; append, set, get and any rejected request then pass the check and
// finish states to the result register, finish waiting for a free output.
// A remove walks the elements above the index through the single memory port
// pair, one element per cycle, in a shift state between check and finish.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the block once a second result is
// ready. Reset empties the list (length 0, alloc_size 1) and clears both
// channels; stored element words are not cleared and are only ever read
// below the length.
`timescale 1ns / 1ps

module indexed_list_buffer_core #(
    parameter int CAPACITY      = ilb_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = ilb_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ilb_pkg::OP_W-1:0]       op,
    input  logic [ilb_pkg::INDEX_W-1:0]    index,
    input  logic [ilb_pkg::VALUE_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ilb_pkg::VALUE_W-1:0]    read_value,
    output logic [ilb_pkg::LENGTH_W-1:0]   length,
    output logic [ilb_pkg::LENGTH_W-1:0]   alloc_size,
    output logic [ilb_pkg::STATUS_W-1:0]   status
);
    import ilb_pkg::*;

    ilb_cmd_t  cmd;
    ilb_stat_t stat;

    // sequencing
    ilb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // storage and arithmetic
    ilb_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .length     (length),
        .alloc_size (alloc_size),
        .status     (status)
    );

endmodule
